// File: rtl/lol_pkg.sv
// Shared types and codes for the lease ownership lock.
// Used by the front, queue, back and top level files; no dependencies.
`default_nettype none
package lol_pkg;

    localparam int IdPortW = 16;
    localparam int TimeW   = 32;

    // item kinds
    localparam logic [1:0] OP_CLAIM     = 2'd0;
    localparam logic [1:0] OP_RELEASE   = 2'd1;
    localparam logic [1:0] OP_HEARTBEAT = 2'd2;
    localparam logic [1:0] OP_TICK      = 2'd3;

    // response status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_TARGET = 2'd1;
    localparam logic [1:0] ST_TAKEN      = 2'd2;
    localparam logic [1:0] ST_NOT_OWNER  = 2'd3;

    localparam logic [15:0] HB_TAG = 16'd0;

    // classified command handed from the front to the back
    typedef struct packed {
        logic [1:0]         op;
        logic               on_target;
        logic [IdPortW-1:0] ctrl;      // masked to the ID width
        logic [15:0]        tag;       // heartbeat tag already applied
        logic [TimeW-1:0]   lease;
        logic [TimeW-1:0]   now;
    } t_cmd;

endpackage
`default_nettype wire

// File: rtl/lease_ownership_lock.sv
// Top level of the lease ownership lock: front, command queue and back.
// Depends on lol_pkg, lol_front, lol_queue and lol_back.
//
//  channel   direction  handshake                     payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   tuser op, tdata request fields
//  m_axis    out        m_axis_tvalid/m_axis_tready   tuser status, tdata response fields
//  cfg       in         i_cfg_we                      i_cfg_wdata own node ID
//
// One beat per cycle in and out while neither side stalls; a request is written to the queue
// when it is taken and reaches the output register when the back pops it (execute against the lock).
// The lock state update is one 32-bit add and a compare in the back stage.
// Reset is synchronous and active low; it frees the lock and clears the node ID.
// A stalled output holds its beat while the two-entry queue keeps taking requests;
// s_axis_tready drops only when the queue is full. Ticks retire without an output.
`default_nettype none
module lease_ownership_lock #(
    parameter int ID_WIDTH = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [15:0]   i_cfg_wdata,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // tdata: target_node[15:0], requester_id[31:16], request_tag[47:32],
    //        lease_len_ms[79:48], now_ms[111:80]
    input  wire logic [111:0]  s_axis_tdata,
    // tuser: op[1:0]
    input  wire logic [1:0]    s_axis_tuser,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // tdata: resp_tag[15:0], resp_node[31:16], resp_controller[47:32],
    //        resp_lease_ms[79:48], expires_at_ms[111:80]
    output logic [111:0]       m_axis_tdata,
    // tuser: status[1:0]
    output logic [1:0]         m_axis_tuser
);

    // IDs narrower than the 16-bit port fields drop their upper bits
    localparam int IdW = (ID_WIDTH < lol_pkg::IdPortW) ? ID_WIDTH : lol_pkg::IdPortW;

    lol_pkg::t_cmd front_cmd;
    lol_pkg::t_cmd head_cmd;
    logic [15:0]   node_id;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;

    assign s_axis_tready = !q_full;

    lol_front #(.ID_W(IdW)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_op        (s_axis_tuser),
        .i_target    (s_axis_tdata[15:0]),
        .i_requester (s_axis_tdata[31:16]),
        .i_tag       (s_axis_tdata[47:32]),
        .i_lease     (s_axis_tdata[79:48]),
        .i_now       (s_axis_tdata[111:80]),
        .o_cmd       (front_cmd),
        .o_node      (node_id)
    );

    // decouple classification from execution so either side can stall
    lol_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid && s_axis_tready),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    lol_back #(.ID_W(IdW)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_cmd    (head_cmd),
        .i_node   (node_id),
        .o_pop    (q_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_tag    (m_axis_tdata[15:0]),
        .o_node   (m_axis_tdata[31:16]),
        .o_ctrl   (m_axis_tdata[47:32]),
        .o_status (m_axis_tuser),
        .o_lease  (m_axis_tdata[79:48]),
        .o_expiry (m_axis_tdata[111:80])
    );

endmodule
`default_nettype wire

// File: rtl/lol_front.sv
// Front end: holds the node ID register and classifies incoming requests.
// Depends on lol_pkg for the command struct and op codes.
`default_nettype none
module lol_front #(
    parameter int ID_W = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [lol_pkg::IdPortW-1:0]    i_cfg_wdata,
    input  wire logic [1:0]                     i_op,
    input  wire logic [lol_pkg::IdPortW-1:0]    i_target,
    input  wire logic [lol_pkg::IdPortW-1:0]    i_requester,
    input  wire logic [15:0]                    i_tag,
    input  wire logic [lol_pkg::TimeW-1:0]      i_lease,
    input  wire logic [lol_pkg::TimeW-1:0]      i_now,
    output lol_pkg::t_cmd                       o_cmd,
    output logic [lol_pkg::IdPortW-1:0]         o_node
);

    localparam logic [lol_pkg::IdPortW-1:0] IdMask =
        lol_pkg::IdPortW'((17'd1 << ID_W) - 17'd1);

    logic [ID_W-1:0] r_node;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node <= '0;
        end else if (i_cfg_we) begin
            r_node <= i_cfg_wdata[ID_W-1:0];
        end
    end

    assign o_node = lol_pkg::IdPortW'(r_node);

    always_comb begin
        o_cmd.op        = i_op;
        o_cmd.on_target = (i_target[ID_W-1:0] == r_node);
        o_cmd.ctrl      = i_requester & IdMask;
        o_cmd.tag       = (i_op == lol_pkg::OP_HEARTBEAT) ? lol_pkg::HB_TAG : i_tag;
        o_cmd.lease     = i_lease;
        o_cmd.now       = i_now;
    end

endmodule
`default_nettype wire

// File: rtl/lol_queue.sv
// Two-entry command queue between front and back; push and pop may share a cycle.
// Depends on lol_pkg for the command struct.
`default_nettype none
module lol_queue (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire lol_pkg::t_cmd i_cmd,
    output logic         o_full,
    input  wire logic    i_pop,
    output logic         o_valid,
    output lol_pkg::t_cmd o_cmd
);

    lol_pkg::t_cmd r_mem [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (i_pop)  r_rd_ptr <= ~r_rd_ptr;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: rtl/lol_back.sv
// Back end: lock state, request execution and the registered response beat.
// Depends on lol_pkg for the command struct, op and status codes.
`default_nettype none
module lol_back #(
    parameter int ID_W = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire lol_pkg::t_cmd                i_cmd,
    input  wire logic [lol_pkg::IdPortW-1:0]  i_node,
    output logic                              o_pop,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [15:0]                       o_tag,
    output logic [lol_pkg::IdPortW-1:0]       o_node,
    output logic [lol_pkg::IdPortW-1:0]       o_ctrl,
    output logic [1:0]                        o_status,
    output logic [lol_pkg::TimeW-1:0]         o_lease,
    output logic [lol_pkg::TimeW-1:0]         o_expiry
);

    logic                        r_held;
    logic [ID_W-1:0]             r_owner;
    logic [lol_pkg::TimeW-1:0]   r_lease;
    logic [lol_pkg::TimeW-1:0]   r_expiry;
    logic                        r_out_valid;

    logic                        n_held;
    logic [ID_W-1:0]             n_owner;
    logic [lol_pkg::TimeW-1:0]   n_lease;
    logic [lol_pkg::TimeW-1:0]   n_expiry;
    logic [1:0]                  status;
    logic [lol_pkg::TimeW-1:0]   add_len;
    logic [lol_pkg::TimeW-1:0]   sum;
    logic                        is_tick;
    logic                        same_owner;

    assign is_tick    = (i_cmd.op == lol_pkg::OP_TICK);
    assign same_owner = (r_owner == i_cmd.ctrl[ID_W-1:0]);
    // ticks retire without touching the output slot
    assign o_pop      = i_valid && (is_tick || !r_out_valid || i_ready);

    assign add_len = (i_cmd.op == lol_pkg::OP_CLAIM) ? i_cmd.lease : r_lease;
    assign sum     = i_cmd.now + add_len;

    always_comb begin
        n_held   = r_held;
        n_owner  = r_owner;
        n_lease  = r_lease;
        n_expiry = r_expiry;
        status   = lol_pkg::ST_OK;
        case (i_cmd.op)
            lol_pkg::OP_CLAIM: begin
                if (!i_cmd.on_target || i_cmd.ctrl == '0) begin
                    status = lol_pkg::ST_BAD_TARGET;
                end else if (!r_held || same_owner) begin
                    n_held   = 1'b1;
                    n_owner  = i_cmd.ctrl[ID_W-1:0];
                    n_lease  = i_cmd.lease;
                    n_expiry = sum;
                end else begin
                    status = lol_pkg::ST_TAKEN;
                end
            end
            lol_pkg::OP_RELEASE: begin
                if (!i_cmd.on_target) begin
                    status = lol_pkg::ST_BAD_TARGET;
                end else if (!(r_held && same_owner)) begin
                    status = lol_pkg::ST_NOT_OWNER;
                end else begin
                    n_held   = 1'b0;
                    n_owner  = '0;
                    n_expiry = '0;
                end
            end
            lol_pkg::OP_HEARTBEAT: begin
                if (!i_cmd.on_target) begin
                    status = lol_pkg::ST_BAD_TARGET;
                end else if (!(r_held && same_owner)) begin
                    status = lol_pkg::ST_NOT_OWNER;
                end else begin
                    n_expiry = sum;
                end
            end
            default: begin
                // plain unsigned compare, no wrap handling
                if (r_held && i_cmd.now > r_expiry) begin
                    n_held   = 1'b0;
                    n_owner  = '0;
                    n_expiry = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= 1'b0;
            r_owner     <= '0;
            r_lease     <= '0;
            r_expiry    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_held   <= n_held;
                r_owner  <= n_owner;
                r_lease  <= n_lease;
                r_expiry <= n_expiry;
            end
            if (o_pop && !is_tick) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && !is_tick) begin
            o_tag    <= i_cmd.tag;
            o_node   <= i_node;
            o_ctrl   <= i_cmd.ctrl;
            o_status <= status;
            o_lease  <= n_lease;
            o_expiry <= (status == lol_pkg::ST_OK) ? n_expiry : i_cmd.now;
        end
    end

    assign o_valid = r_out_valid;

    // a held lock always has a non-empty owner
    a_held_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held |-> r_owner != '0)
        else $error("held lock with empty owner");

    // a free lock carries no owner and no expiry
    a_free_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_held |-> (r_owner == '0 && r_expiry == '0))
        else $error("free lock keeps owner or expiry");

    // a tick does not disturb a pending response beat
    a_no_tick_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && is_tick && r_out_valid && !i_ready) |=> r_out_valid)
        else $error("tick disturbed a pending response");

    a_beat_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && !(o_pop && !is_tick)) |=> !r_out_valid)
        else $error("response beat without a request");

endmodule
`default_nettype wire
